// ----- src/ltlb_pkg.sv -----
// types and constants for the level threshold led blinker
// no dependencies; used by level_threshold_led_blinker
package ltlb_pkg;

  localparam int unsigned NumCh      = 8;
  localparam int unsigned ChW        = 3;
  localparam int unsigned SampleW    = 10;
  localparam int unsigned LedW       = 8;
  localparam int unsigned CfgIdxW    = 4;
  localparam int unsigned CfgDataW   = 30;
  localparam int unsigned InDataW    = 16;
  localparam int unsigned SlowCountW = 6;
  localparam int unsigned FastCountW = 4;

  // blink counter limits, a phase toggles once the old count exceeds them
  localparam logic [SlowCountW-1:0] SlowLimit = 6'd50;
  localparam logic [FastCountW-1:0] FastLimit = 4'd10;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_TICK   = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    LVL_OFF    = 2'd0,
    LVL_SLOW   = 2'd1,
    LVL_FAST   = 2'd2,
    LVL_STEADY = 2'd3
  } level_e;

  // per-channel threshold register, off limit in the low bits
  typedef struct packed {
    logic [SampleW-1:0] fast_lim;
    logic [SampleW-1:0] slow_lim;
    logic [SampleW-1:0] off_lim;
  } thr_t;

  // request payload on tdata, channel in the low bits
  typedef struct packed {
    logic [InDataW-ChW-SampleW-1:0] pad;
    logic [SampleW-1:0]             sample;
    logic [ChW-1:0]                 channel;
  } in_data_t;

  // request held in the input stage
  typedef struct packed {
    cmd_e               cmd;
    logic [ChW-1:0]     channel;
    logic [SampleW-1:0] sample;
  } req_t;

  function automatic level_e classify(thr_t thr, logic [SampleW-1:0] s);
    level_e lvl;
    if (s < thr.off_lim) begin
      lvl = LVL_OFF;
    end else if (s < thr.slow_lim) begin
      lvl = LVL_SLOW;
    end else if (s < thr.fast_lim) begin
      lvl = LVL_FAST;
    end else begin
      lvl = LVL_STEADY;
    end
    return lvl;
  endfunction

endpackage

// ----- src/level_threshold_led_blinker.sv -----
// level threshold led blinker: eight-channel level indicator, top level
// depends on ltlb_pkg

// A sample request (tuser 0) sorts a 10-bit reading of one channel into off,
// slow blink, fast blink or steady on by that channel's three thresholds and
// stores the level; a tick request (tuser 1) advances the slow and fast blink
// counters and redraws all eight LED bits. Every request returns the LED
// register as one result. The block takes one request per cycle: a request
// is held in the input register, is processed as it moves into the output
// register, and its result is presented from there. The only thing that slows
// it is backpressure on the result side. Thresholds must be written by the user
// over the cfg port only while no request is in flight; it is not enforced.
module level_threshold_led_blinker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [2:0] channel, [12:3] sample, [15:13] zero
  input  logic [ltlb_pkg::InDataW-1:0]   s_axis_tdata_i,
  // [0] cmd
  input  logic                           s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [7:0] led_drive
  output logic [ltlb_pkg::LedW-1:0]      m_axis_tdata_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ltlb_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ltlb_pkg::CfgDataW-1:0]  cfg_data_i
);

  ltlb_pkg::thr_t   thr_q [ltlb_pkg::NumCh];
  ltlb_pkg::level_e level_q [ltlb_pkg::NumCh];

  ltlb_pkg::req_t   req_q;
  logic             req_valid_q;
  logic             out_valid_q;
  logic [ltlb_pkg::LedW-1:0] out_data_q;

  logic [ltlb_pkg::SlowCountW-1:0] slow_count_q, slow_count_d;
  logic [ltlb_pkg::FastCountW-1:0] fast_count_q, fast_count_d;
  logic                            slow_phase_q, slow_phase_d;
  logic                            fast_phase_q, fast_phase_d;
  logic [ltlb_pkg::LedW-1:0]       led_q, led_d;

  ltlb_pkg::in_data_t in_data;
  ltlb_pkg::level_e   new_level;
  logic               out_free;
  logic               advance;
  logic               in_accept;
  logic               is_tick;

  assign in_data   = ltlb_pkg::in_data_t'(s_axis_tdata_i);
  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign advance   = req_valid_q && out_free;
  assign s_axis_tready_o = !req_valid_q || out_free;
  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign is_tick   = (req_q.cmd == ltlb_pkg::CMD_TICK);
  assign cfg_ready_o = 1'b1;

  assign new_level = ltlb_pkg::classify(thr_q[req_q.channel], req_q.sample);

  // blink counters and led redraw on a tick
  always_comb begin
    slow_count_d = slow_count_q;
    fast_count_d = fast_count_q;
    slow_phase_d = slow_phase_q;
    fast_phase_d = fast_phase_q;
    led_d        = led_q;
    if (is_tick) begin
      if (slow_count_q > ltlb_pkg::SlowLimit) begin
        slow_phase_d = !slow_phase_q;
        slow_count_d = '0;
      end else begin
        slow_count_d = slow_count_q + 1'b1;
      end
      if (fast_count_q > ltlb_pkg::FastLimit) begin
        fast_phase_d = !fast_phase_q;
        fast_count_d = '0;
      end else begin
        fast_count_d = fast_count_q + 1'b1;
      end
      for (int i = 0; i < ltlb_pkg::NumCh; i++) begin
        unique case (level_q[i])
          ltlb_pkg::LVL_OFF:    led_d[i] = 1'b0;
          ltlb_pkg::LVL_SLOW:   led_d[i] = slow_phase_d;
          ltlb_pkg::LVL_FAST:   led_d[i] = fast_phase_d;
          ltlb_pkg::LVL_STEADY: led_d[i] = 1'b1;
          default:              led_d[i] = 1'b0;
        endcase
      end
    end
  end

  // threshold registers, indexes beyond the channel count are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ltlb_pkg::NumCh; i++) begin
        thr_q[i] <= '0;
      end
    end else if (cfg_valid_i && cfg_ready_o &&
                 (cfg_index_i < ltlb_pkg::CfgIdxW'(ltlb_pkg::NumCh))) begin
      thr_q[cfg_index_i[ltlb_pkg::ChW-1:0]] <= ltlb_pkg::thr_t'(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      req_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q.cmd     <= ltlb_pkg::cmd_e'(s_axis_tuser_i);
      req_q.channel <= in_data.channel;
      req_q.sample  <= in_data.sample;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ltlb_pkg::NumCh; i++) begin
        level_q[i] <= ltlb_pkg::LVL_OFF;
      end
      slow_count_q <= '0;
      fast_count_q <= '0;
      slow_phase_q <= 1'b0;
      fast_phase_q <= 1'b0;
      led_q        <= '0;
    end else if (advance) begin
      if (!is_tick) begin
        level_q[req_q.channel] <= new_level;
      end
      slow_count_q <= slow_count_d;
      fast_count_q <= fast_count_d;
      slow_phase_q <= slow_phase_d;
      fast_phase_q <= fast_phase_d;
      led_q        <= led_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= led_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  a_slow_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slow_count_q <= ltlb_pkg::SlowLimit + 1'b1)
    else $error("slow blink count out of range");

  a_fast_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fast_count_q <= ltlb_pkg::FastLimit + 1'b1)
    else $error("fast blink count out of range");

  a_sample_keeps_led: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !is_tick) |=> $stable(led_q))
    else $error("sample request changed the led register");

  a_result_matches_led: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o == led_q))
    else $error("pending result differs from led register");

endmodule
